FILE: hdl/ica_pkg.sv
package ica_pkg;

	localparam int unsigned QW    = 32;
	localparam int unsigned IDX_W = 6;
	localparam int unsigned CNT_W = 7;
	localparam int unsigned NUM_W = 65;

	typedef enum logic [2:0] {
		FN_LOAD = 3'd0,
		FN_ADD  = 3'd1,
		FN_SUB  = 3'd2,
		FN_MUL  = 3'd3,
		FN_DIV  = 3'd4
	} func_t;

	typedef struct packed {
		func_t             func;
		logic [IDX_W-1:0]  ref_index;
		logic [QW-1:0]     x_value;
		logic [QW-1:0]     y_value;
		logic              query_last;
	} item_t;

endpackage

FILE: hdl/interpolated_curve_arithmetic_unit.sv
// Piecewise-linear reference curve unit, signed Q16.16. Load requests (func 0) write one
// (x, y) point into a table of MAX_POINTS slots; query requests scan the first point_count
// slots (point_count clamped to 1..MAX_POINTS) for the bracketing points, interpolate a
// reference value at x and add, subtract, multiply or divide it into y, saturating and
// flagging the result. Requests pass through a two-entry queue to a single sequencer that
// handles one request at a time. A load is written directly from the idle state. Queries
// scan the table one entry per cycle and share one divider, one quotient bit per cycle,
// between interpolation and the divide operation; a stalled result port holds the sequencer
// in its final state until the output register is free. The table has no reset; query only
// written slots.
module interpolated_curve_arithmetic_unit #(
	parameter int MAX_POINTS = 64,
	parameter int FRAC_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // func[2:0], ref_index[8:3], x_value[40:9], y_value[72:41]
	input  logic        s_tlast,   // query_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // new_y[31:0], in_range, div_by_zero, saturated
	output logic        m_tlast,   // last_out
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data   // point_count
);
	import ica_pkg::*;

	logic             q_full, q_push, q_valid, q_pop;
	item_t            q_in, q_out;
	logic [CNT_W-1:0] point_count_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= CNT_W'(1);
		end else if (cfg_valid) begin
			point_count_q <= cfg_data;
		end
	end

	ica_front u_front (
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_item  (q_in)
	);

	ica_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_in),
		.full  (q_full),
		.valid (q_valid),
		.dout  (q_out),
		.pop   (q_pop)
	);

	ica_back #(
		.MAX_POINTS(MAX_POINTS),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_out),
		.q_pop      (q_pop),
		.point_count(point_count_q),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

FILE: hdl/ica_front.sv
module ica_front (
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [79:0]    s_tdata,   // func[2:0], ref_index[8:3], x_value[40:9], y_value[72:41]
	input  logic           s_tlast,
	input  logic           q_full,
	output logic           q_push,
	output ica_pkg::item_t q_item
);
	import ica_pkg::*;

	logic known;

	always_comb begin
		q_item.func       = func_t'(s_tdata[2:0]);
		q_item.ref_index  = s_tdata[8:3];
		q_item.x_value    = s_tdata[40:9];
		q_item.y_value    = s_tdata[72:41];
		q_item.query_last = s_tlast;
		case (s_tdata[2:0])
			FN_LOAD, FN_ADD, FN_SUB, FN_MUL, FN_DIV: known = 1'b1;
			default: known = 1'b0;
		endcase
	end

	// unknown operations are taken and dropped
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full && known;

endmodule

FILE: hdl/ica_queue.sv
module ica_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ica_pkg::item_t din,
	output logic           full,
	output logic           valid,
	output ica_pkg::item_t dout,
	input  logic           pop
);
	import ica_pkg::*;

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign dout  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= din;
	end

endmodule

FILE: hdl/ica_div.sv
module ica_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ica_pkg::NUM_W-1:0]  num,
	input  logic [ica_pkg::QW-1:0]     den,
	output logic                       done,
	output logic [ica_pkg::NUM_W-1:0]  quot
);
	import ica_pkg::*;

	localparam int unsigned SW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [QW-1:0]    den_q;
	logic [QW-1:0]    rem_q;
	logic [SW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [QW:0]      rs;
	logic             ge;
	logic [QW:0]      diff;

	always_comb begin
		rs   = {rem_q, num_q[NUM_W-1]};
		ge   = (rs >= {1'b0, den_q});
		diff = rs - {1'b0, den_q};
	end

	// restoring divide, one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				num_q  <= num;
				den_q  <= den;
				rem_q  <= '0;
				cnt_q  <= SW'(NUM_W);
			end else if (busy_q) begin
				rem_q <= ge ? diff[QW-1:0] : rs[QW-1:0];
				num_q <= {num_q[NUM_W-2:0], ge};
				cnt_q <= cnt_q - SW'(1);
				if (cnt_q == SW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

FILE: hdl/ica_back.sv
module ica_back #(
	parameter int MAX_POINTS = 64,
	parameter int FRAC_BITS  = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	input  ica_pkg::item_t            q_item,
	output logic                      q_pop,
	input  logic [ica_pkg::CNT_W-1:0] point_count,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [39:0]               m_tdata,  // new_y[31:0], in_range, div_by_zero, saturated
	output logic                      m_tlast
);
	import ica_pkg::*;

	localparam int AW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
	localparam int NW = $clog2(MAX_POINTS + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_UPRD, S_SCAN, S_CHECK, S_IMUL, S_IDIV, S_IWAIT,
		S_OP, S_OMUL, S_OMULR, S_ODIV, S_OWAIT, S_FIN
	} state_t;

	state_t st_q;

	logic signed [QW-1:0] mem_x [MAX_POINTS];
	logic signed [QW-1:0] mem_y [MAX_POINTS];
	logic signed [QW-1:0] rd_x_q, rd_y_q;
	logic [AW-1:0]        rd_addr;
	logic                 wr_en;

	func_t                op_q;
	logic signed [QW-1:0] qx_q, qy_q, ref_q;
	logic                 last_q;
	logic [NW-1:0]        n_q, iss_q, n_cl;
	logic                 rd_up_q, rd_v_q, rd_first_q, rd_end_q;
	logic signed [QW-1:0] lo_x_q, lo_y_q, up_x_q, up_y_q;
	logic [QW-1:0]        ma_q, mb_q, den_q;
	logic [2*QW-1:0]      prod_q;
	logic                 dneg_q;
	logic [QW-1:0]        res_q;
	logic                 inr_q, dz_q, sat_q;
	logic                 ov_q;
	logic [QW-1:0]        oy_q;
	logic                 oinr_q, odz_q, osat_q, olast_q;

	logic                 div_start, div_done;
	logic [NUM_W-1:0]     div_num, div_quot;

	logic [QW:0]          t33, d33, dy33, dymag33, add33, sub33;
	logic [QW+1:0]        ref34;
	logic [QW-1:0]        mag_qy, mag_ref;
	logic [NUM_W-1:0]     mulr, cmag;
	logic                 cneg, csat, out_free;
	logic [QW-1:0]        cval;

	ica_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (st_q == S_IDIV ? den_q : mag_ref),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_comb begin
		if (point_count == '0) n_cl = NW'(1);
		else if (int'(point_count) > MAX_POINTS) n_cl = NW'(MAX_POINTS);
		else n_cl = NW'(point_count);

		t33     = {qx_q[QW-1], qx_q} - {lo_x_q[QW-1], lo_x_q};
		d33     = {up_x_q[QW-1], up_x_q} - {lo_x_q[QW-1], lo_x_q};
		dy33    = {up_y_q[QW-1], up_y_q} - {lo_y_q[QW-1], lo_y_q};
		dymag33 = dy33[QW] ? (~dy33 + 1'b1) : dy33;
		ref34   = dneg_q ? ({{2{lo_y_q[QW-1]}}, lo_y_q} - {2'b00, div_quot[QW-1:0]})
		                 : ({{2{lo_y_q[QW-1]}}, lo_y_q} + {2'b00, div_quot[QW-1:0]});
		add33   = {qy_q[QW-1], qy_q} + {ref_q[QW-1], ref_q};
		sub33   = {qy_q[QW-1], qy_q} - {ref_q[QW-1], ref_q};
		mag_qy  = qy_q[QW-1] ? (~qy_q + 1'b1) : qy_q;
		mag_ref = ref_q[QW-1] ? (~ref_q + 1'b1) : ref_q;
		mulr    = ({1'b0, prod_q} + (NUM_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;

		div_start = (st_q == S_IDIV) || (st_q == S_ODIV);
		if (st_q == S_IDIV) div_num = {1'b0, prod_q} + NUM_W'(den_q >> 1);
		else div_num = (NUM_W'(mag_qy) << FRAC_BITS) + NUM_W'(mag_ref >> 1);

		// sign and clip a magnitude
		cmag = (st_q == S_OMULR) ? mulr : div_quot;
		cneg = qy_q[QW-1] ^ ref_q[QW-1];
		if (cneg) begin
			csat = (cmag > (NUM_W'(1) << (QW - 1)));
			cval = csat ? {1'b1, {(QW-1){1'b0}}} : (~cmag[QW-1:0] + 1'b1);
		end else begin
			csat = (cmag > NUM_W'({1'b0, {(QW-1){1'b1}}}));
			cval = csat ? {1'b0, {(QW-1){1'b1}}} : cmag[QW-1:0];
		end

		case (st_q)
			S_UPRD:  rd_addr = AW'(n_q - NW'(1));
			default: rd_addr = iss_q[AW-1:0];
		endcase

		wr_en    = (st_q == S_IDLE) && q_valid && (q_item.func == FN_LOAD)
		           && (int'(q_item.ref_index) < MAX_POINTS);
		q_pop    = (st_q == S_IDLE) && q_valid;
		out_free = !ov_q || m_tready;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[AW'(q_item.ref_index)] <= q_item.x_value;
			mem_y[AW'(q_item.ref_index)] <= q_item.y_value;
		end
		rd_x_q <= mem_x[rd_addr];
		rd_y_q <= mem_y[rd_addr];
		prod_q <= ma_q * mb_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			op_q       <= FN_ADD;
			qx_q       <= '0;
			qy_q       <= '0;
			ref_q      <= '0;
			last_q     <= 1'b0;
			n_q        <= '0;
			iss_q      <= '0;
			rd_up_q    <= 1'b0;
			rd_v_q     <= 1'b0;
			rd_first_q <= 1'b0;
			rd_end_q   <= 1'b0;
			lo_x_q     <= '0;
			lo_y_q     <= '0;
			up_x_q     <= '0;
			up_y_q     <= '0;
			ma_q       <= '0;
			mb_q       <= '0;
			den_q      <= '0;
			dneg_q     <= 1'b0;
			res_q      <= '0;
			inr_q      <= 1'b0;
			dz_q       <= 1'b0;
			sat_q      <= 1'b0;
			ov_q       <= 1'b0;
			oy_q       <= '0;
			oinr_q     <= 1'b0;
			odz_q      <= 1'b0;
			osat_q     <= 1'b0;
			olast_q    <= 1'b0;
		end else begin
			if (ov_q && m_tready && st_q != S_FIN) ov_q <= 1'b0;
			rd_up_q <= (st_q == S_UPRD);
			rd_v_q  <= (st_q == S_SCAN) && (iss_q < n_q);
			case (st_q)
				S_IDLE: begin
					if (q_valid && q_item.func != FN_LOAD) begin
						op_q   <= q_item.func;
						qx_q   <= q_item.x_value;
						qy_q   <= q_item.y_value;
						last_q <= q_item.query_last;
						n_q    <= n_cl;
						st_q   <= S_UPRD;
					end
				end
				S_UPRD: begin
					iss_q   <= '0;
					st_q    <= S_SCAN;
				end
				S_SCAN: begin
					if (iss_q < n_q) begin
						rd_first_q <= (iss_q == '0);
						rd_end_q   <= (iss_q == n_q - NW'(1));
						iss_q      <= iss_q + NW'(1);
					end
					if (rd_up_q) begin
						up_x_q <= rd_x_q;
						up_y_q <= rd_y_q;
					end
					if (rd_v_q) begin
						if (rd_first_q || (rd_x_q >= lo_x_q && rd_x_q <= qx_q)) begin
							lo_x_q <= rd_x_q;
							lo_y_q <= rd_y_q;
						end
						if (rd_x_q < up_x_q && rd_x_q >= qx_q) begin
							up_x_q <= rd_x_q;
							up_y_q <= rd_y_q;
						end
						if (rd_end_q) st_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					dz_q  <= 1'b0;
					sat_q <= 1'b0;
					inr_q <= !(qx_q < lo_x_q || qx_q > up_x_q);
					if (qx_q < lo_x_q || qx_q > up_x_q) begin
						res_q <= qy_q;
						st_q  <= S_FIN;
					end else if (lo_x_q == up_x_q) begin
						ref_q <= up_y_q;
						st_q  <= S_OP;
					end else begin
						ma_q   <= t33[QW-1:0];
						mb_q   <= dymag33[QW-1:0];
						den_q  <= d33[QW-1:0];
						dneg_q <= dy33[QW];
						st_q   <= S_IMUL;
					end
				end
				S_IMUL: st_q <= S_IDIV;
				S_IDIV: st_q <= S_IWAIT;
				S_IWAIT: begin
					if (div_done) begin
						ref_q <= ref34[QW-1:0];
						st_q  <= S_OP;
					end
				end
				S_OP: begin
					case (op_q)
						FN_ADD: begin
							sat_q <= add33[QW] != add33[QW-1];
							res_q <= (add33[QW] != add33[QW-1])
							         ? {add33[QW], {(QW-1){!add33[QW]}}} : add33[QW-1:0];
							st_q  <= S_FIN;
						end
						FN_SUB: begin
							sat_q <= sub33[QW] != sub33[QW-1];
							res_q <= (sub33[QW] != sub33[QW-1])
							         ? {sub33[QW], {(QW-1){!sub33[QW]}}} : sub33[QW-1:0];
							st_q  <= S_FIN;
						end
						FN_MUL: begin
							ma_q <= mag_qy;
							mb_q <= mag_ref;
							st_q <= S_OMUL;
						end
						default: begin
							if (ref_q == '0) begin
								dz_q  <= 1'b1;
								sat_q <= 1'b1;
								res_q <= {qy_q[QW-1], {(QW-1){!qy_q[QW-1]}}};
								st_q  <= S_FIN;
							end else begin
								st_q <= S_ODIV;
							end
						end
					endcase
				end
				S_OMUL: st_q <= S_OMULR;
				S_OMULR: begin
					res_q <= cval;
					sat_q <= csat;
					st_q  <= S_FIN;
				end
				S_ODIV: st_q <= S_OWAIT;
				S_OWAIT: begin
					if (div_done) begin
						res_q <= cval;
						sat_q <= csat;
						st_q  <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						ov_q    <= 1'b1;
						oy_q    <= res_q;
						oinr_q  <= inr_q;
						odz_q   <= dz_q;
						osat_q  <= sat_q;
						olast_q <= last_q;
						st_q    <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {5'b0, osat_q, odz_q, oinr_q, oy_q};
	assign m_tlast  = olast_q;

endmodule

FILE: test/interpolated_curve_arithmetic_unit_checker.sv
module interpolated_curve_arithmetic_unit_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [79:0] s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic        m_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [6:0]  cfg_data,
	output int          fails,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import ica_pkg::*;

	localparam int SLOTS = 64;
	localparam int FRAC = 16;
	localparam longint Q_HI = 64'sd2147483647;
	localparam longint Q_LO = -64'sd2147483648;

	typedef struct {
		bit [31:0] new_y;
		bit        in_range;
		bit        div_by_zero;
		bit        saturated;
		bit        last;
	} curve_result_t;

	int            curve_x[SLOTS];
	int            curve_y[SLOTS];
	bit [6:0]      point_count;
	curve_result_t pending_results[$];
	int            mismatches;

	assign fails = mismatches;
	assign outstanding = pending_results.size();

	function automatic bit [63:0] magnitude(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic bit [63:0] div_round(bit [63:0] n, bit [63:0] d);
		return (n + d / 2) / d;
	endfunction

	function automatic longint clip_q(longint v, inout bit sat);
		if (v > Q_HI) begin
			sat = 1'b1;
			return Q_HI;
		end
		if (v < Q_LO) begin
			sat = 1'b1;
			return Q_LO;
		end
		return v;
	endfunction

	function automatic longint sign_clip_q(bit [63:0] m, bit neg, inout bit sat);
		longint v;
		if (m > 64'h4000_0000_0000_0000)
			m = 64'h4000_0000_0000_0000;
		v = longint'(m);
		return clip_q(neg ? -v : v, sat);
	endfunction

	function automatic curve_result_t combine_query(bit [2:0] op, int qx, int qy, bit last);
		curve_result_t r;
		int            n, lo, up;
		longint        xl, xu, yl, yu, dy, refv, res;
		bit [63:0]     q, m;
		bit            sat;
		sat = 1'b0;
		n = point_count;
		if (n < 1)
			n = 1;
		if (n > SLOTS)
			n = SLOTS;
		lo = 0;
		up = n - 1;
		for (int s = 0; s < n; s++) begin
			if (curve_x[s] >= curve_x[lo] && curve_x[s] <= qx)
				lo = s;
			if (curve_x[s] < curve_x[up] && curve_x[s] >= qx)
				up = s;
		end
		xl = curve_x[lo];
		xu = curve_x[up];
		yl = curve_y[lo];
		yu = curve_y[up];
		r.last = last;
		r.div_by_zero = 1'b0;
		if (qx < xl || qx > xu) begin
			r.new_y = qy;
			r.in_range = 1'b0;
			r.saturated = 1'b0;
			return r;
		end
		if (xl == xu) begin
			refv = yu;
		end else begin
			dy = yu - yl;
			q = div_round(64'(longint'(qx) - xl) * magnitude(dy), 64'(xu - xl));
			refv = dy < 0 ? yl - longint'(q) : yl + longint'(q);
		end
		case (op)
			FN_ADD: res = clip_q(longint'(qy) + refv, sat);
			FN_SUB: res = clip_q(longint'(qy) - refv, sat);
			FN_MUL: begin
				m = magnitude(qy) * magnitude(refv);
				m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
				res = sign_clip_q(m, (qy < 0) != (refv < 0), sat);
			end
			default: begin
				if (refv == 0) begin
					r.div_by_zero = 1'b1;
					sat = 1'b1;
					res = qy < 0 ? Q_LO : Q_HI;
				end else begin
					m = div_round(magnitude(qy) << FRAC, magnitude(refv));
					res = sign_clip_q(m, (qy < 0) != (refv < 0), sat);
				end
			end
		endcase
		r.new_y = res[31:0];
		r.in_range = 1'b1;
		r.saturated = sat;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bit [2:0]      op;
		curve_result_t want;
		curve_result_t got;
		if (!arst_n) begin
			point_count = 7'd1;
			pending_results.delete();
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				point_count = cfg_data;
			if (s_tvalid && s_tready) begin
				op = s_tdata[2:0];
				if (op == FN_LOAD) begin
					curve_x[s_tdata[8:3]] = s_tdata[40:9];
					curve_y[s_tdata[8:3]] = s_tdata[72:41];
				end else if (op <= FN_DIV) begin
					pending_results.push_back(combine_query(op, s_tdata[40:9],
						s_tdata[72:41], s_tlast));
				end
			end
			if (m_tvalid && m_tready) begin
				got.new_y = m_tdata[31:0];
				got.in_range = m_tdata[32];
				got.div_by_zero = m_tdata[33];
				got.saturated = m_tdata[34];
				got.last = m_tlast;
				if (pending_results.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result y=%h flags=%b%b%b last=%b", got.new_y,
							got.in_range, got.div_by_zero, got.saturated, got.last);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					if (want != got) begin
						if (mismatches < 10)
							$display("result mismatch: expected y=%h flags=%b%b%b last=%b, got y=%h flags=%b%b%b last=%b",
								want.new_y, want.in_range, want.div_by_zero, want.saturated,
								want.last, got.new_y, got.in_range, got.div_by_zero,
								got.saturated, got.last);
						mismatches++;
					end
				end
			end
		end
	end

	final begin
	end
endmodule

FILE: test/interpolated_curve_arithmetic_unit_test.sv
module interpolated_curve_arithmetic_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import ica_pkg::*;

	localparam int SLOTS = 64;
	localparam int DRAIN = 300;
	localparam longint CYCLE_LIMIT = 1500000;
	localparam int Q_HI = 32'h7fffffff;
	localparam int Q_LO = 32'h80000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [6:0]  cfg_data = 7'd0;
	int          fails;
	int          outstanding;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	longint      cycles = 0;
	int          curve_pts[$];

	interpolated_curve_arithmetic_unit dut (.*);

	interpolated_curve_arithmetic_unit_checker checker_i (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("interpolated_curve_arithmetic_unit_test: errors");
			$finish;
		end
	end

	always @(negedge clk)
		m_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);

	task automatic send_request(bit [2:0] op, bit [5:0] slot, int x, int y, bit last);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, y, x, slot, op};
		s_tlast <= last;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	task automatic write_point_count(bit [6:0] value);
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic int pick_y();
		case ($urandom_range(9))
			0: return 0;
			1: return Q_HI;
			2: return Q_LO;
			3, 4, 5: return int'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic load_random_curve(int n);
		int style;
		int ys;
		bit [5:0] order[$];
		curve_pts.delete();
		style = $urandom_range(3);
		for (int i = 0; i < n; i++) begin
			if (style == 0)
				curve_pts.push_back(int'($urandom_range(0, 40)) * 65536 - 20 * 65536);
			else
				curve_pts.push_back($urandom);
		end
		if ($urandom_range(5) != 0)
			curve_pts.sort();
		for (int i = 0; i < n; i++)
			order.push_back(i);
		order.shuffle();
		foreach (order[k]) begin
			ys = ($urandom_range(7) == 0) ? 0 : pick_y();
			send_request(FN_LOAD, order[k], curve_pts[order[k]], ys, $urandom_range(1));
		end
	endtask

	function automatic int pick_x();
		int     i;
		longint a, b;
		case ($urandom_range(19))
			0, 1, 2: return curve_pts[$urandom_range(curve_pts.size() - 1)];
			3, 4, 5, 6, 7, 8: return $urandom;
			9: return ($urandom_range(1)) ? Q_HI : Q_LO;
			default: begin
				i = $urandom_range(curve_pts.size() - 1);
				a = curve_pts[i];
				b = curve_pts[(i + 1) % curve_pts.size()];
				if (a > b) begin
					a = b;
					b = curve_pts[i];
				end
				return int'(a + longint'({$urandom, $urandom} % 64'(b - a + 1)));
			end
		endcase
	endfunction

	function automatic int grid_x(int s);
		return (s == 21) ? (20 - 32) <<< 26 : (s - 32) <<< 26;
	endfunction

	initial begin
		int counts[9] = '{64, 2, 127, 37, 0, 64, 65, 1, 0};
		int n;
		int y;
		int r;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// full table first so no query ever reads an unwritten slot
		for (int s = 0; s < SLOTS; s++) begin
			case (s)
				5: y = Q_HI;
				6: y = Q_LO;
				10: y = 0;
				default: y = (s * 40503 - 1200000) ^ (s << 20);
			endcase
			send_request(FN_LOAD, s, grid_x(s), y, s[0]);
		end
		send_request(FN_ADD, 0, Q_LO, 12345, 1'b0);
		send_request(FN_SUB, 0, Q_HI, -77, 1'b1);
		write_point_count(7'd64);
		send_request(FN_ADD, 0, grid_x(20), 65536, 1'b0);
		send_request(FN_DIV, 0, grid_x(10), 65536, 1'b0);
		send_request(FN_DIV, 0, grid_x(10), -3, 1'b1);
		send_request(FN_ADD, 0, grid_x(5), Q_HI, 1'b0);
		send_request(FN_SUB, 0, grid_x(5), Q_LO, 1'b0);
		send_request(FN_SUB, 0, grid_x(6), Q_HI, 1'b0);
		send_request(FN_MUL, 0, grid_x(5), Q_HI, 1'b0);
		send_request(FN_MUL, 0, grid_x(6), Q_HI, 1'b1);
		send_request(FN_MUL, 0, grid_x(5) + 32'h0200_0000, -98765, 1'b0);
		send_request(FN_DIV, 0, grid_x(10) + 1, Q_HI, 1'b0);
		send_request(FN_DIV, 0, grid_x(30) + 32'h0123_4567, Q_LO, 1'b0);
		send_request(FN_ADD, 0, Q_HI, 5, 1'b1);
		send_request(3'd5, 6'h3f, Q_HI, Q_LO, 1'b1);
		send_request(3'd6, 0, 0, 0, 1'b0);
		send_request(3'd7, 6'h2a, -1, -1, 1'b1);
		send_request(FN_MUL, 0, grid_x(40) + 32'h0080_0000, 0, 1'b1);

		for (int ph = 0; ph < 9; ph++) begin
			if (ph < 3) begin
				send_idle_pct = 36;
				recv_idle_pct = 54;
			end else if (ph < 6) begin
				send_idle_pct = 54;
				recv_idle_pct = 36;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			n = (ph == 8) ? $urandom_range(1, 64) : counts[ph];
			write_point_count(7'(n));
			if (n < 1)
				n = 1;
			if (n > SLOTS)
				n = SLOTS;
			load_random_curve(n);
			for (int k = 0; k < 76; k++) begin
				r = $urandom_range(39);
				if (r == 0)
					send_request(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom,
						$urandom_range(1));
				else if (r == 1)
					send_request(FN_LOAD, $urandom, $urandom, pick_y(), $urandom_range(1));
				else
					send_request(3'($urandom_range(FN_ADD, FN_DIV)), $urandom, pick_x(),
						pick_y(), $urandom_range(1));
			end
		end

		s_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
		if (fails == 0)
			$display("interpolated_curve_arithmetic_unit_test: clean");
		else
			$display("interpolated_curve_arithmetic_unit_test: errors");
		$finish;
	end
endmodule

FILE: sim.f
hdl/ica_pkg.sv
hdl/ica_front.sv
hdl/ica_queue.sv
hdl/ica_div.sv
hdl/ica_back.sv
hdl/interpolated_curve_arithmetic_unit.sv
test/interpolated_curve_arithmetic_unit_checker.sv
test/interpolated_curve_arithmetic_unit_test.sv
